// ===== rtl/core/srw_pkg.sv =====
// Shared types and constants of the selective-repeat receive window.
// Used by every module under rtl/core; depends on nothing.
package srw_pkg;

   localparam int WINDOW_MAX_DEF  = 8;
   localparam int MAX_PAYLOAD_DEF = 1024;

   localparam int SEQ_W   = 31;
   localparam int LEN_W   = 11;
   localparam int REF_W   = 32;
   localparam int KIND_W  = 3;
   localparam int WSIZE_W = 4;
   localparam int CNT_W   = 16;

   // stream payload layout, lowest bit first
   localparam int SEQ_LO  = 0;
   localparam int LEN_LO  = SEQ_LO + SEQ_W;
   localparam int REF_LO  = LEN_LO + LEN_W;
   localparam int TDATA_W = ((REF_LO + REF_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST  = WSIZE_W'(8);
   localparam logic [CNT_W-1:0]   BUFFER_LIMIT_RST = CNT_W'(256);
   localparam logic [SEQ_W-1:0]   WINDOW_START_RST = SEQ_W'(1);

   localparam int CMD_QUEUE_DEPTH = 2;

   typedef enum logic {
      CSR_WINDOW_SIZE  = 1'b0,
      CSR_BUFFER_LIMIT = 1'b1
   } csr_reg_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK     = 3'd0,
      KIND_NACK    = 3'd1,
      KIND_DELIVER = 3'd2,
      KIND_FLUSH   = 3'd3,
      KIND_END     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      OP_NACK = 2'd0,
      OP_END  = 2'd1,
      OP_DATA = 2'd2
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SEQ_W-1:0]  seq;
      logic [LEN_W-1:0]  len;
      logic [REF_W-1:0]  handle;
   } cmd_type;

   typedef struct packed {
      logic [WSIZE_W-1:0] window_size;
      logic [CNT_W-1:0]   buffer_limit;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [SEQ_W-1:0]  seq;
      logic [LEN_W-1:0]  len;
      logic [REF_W-1:0]  handle;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/core/srw_front.sv =====
// Front end: accepts packet beats, sorts them into commands, drops beats after end of transfer.
// Depends on srw_pkg.
module srw_front
   import srw_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_ok,
   input  logic [SEQ_W-1:0] req_seq,
   input  logic [LEN_W-1:0] req_len,
   input  logic [REF_W-1:0] req_handle,
   input  logic             queue_full,
   output logic             push,
   output cmd_type          push_cmd
);

   logic done_ff;
   logic done_in;
   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept && !done_ff;

   always_comb begin
      push_cmd.seq    = req_seq;
      push_cmd.handle = req_handle;
      push_cmd.len    = req_len;
      // clamp overlong payloads
      if (32'(req_len) > 32'(MAX_PAYLOAD)) begin
         push_cmd.len = LEN_W'(MAX_PAYLOAD);
      end
      priority if (!req_ok) begin
         push_cmd.op = OP_NACK;
      end else if (req_len == '0) begin
         push_cmd.op = OP_END;
      end else begin
         push_cmd.op = OP_DATA;
      end
   end

   // once the end packet is queued, drop every later beat
   assign done_in = done_ff || (push && push_cmd.op == OP_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

endmodule

// ===== rtl/core/srw_cmd_queue.sv =====
// Short command queue between front end and back end.
// Depends on srw_pkg.
module srw_cmd_queue
   import srw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   localparam int PtrW = $clog2(CMD_QUEUE_DEPTH);
   localparam int CntW = $clog2(CMD_QUEUE_DEPTH + 1);

   cmd_type           entry_ff [CMD_QUEUE_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full      = (32'(count_ff) == CMD_QUEUE_DEPTH);
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == CMD_QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == CMD_QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/srw_back.sv =====
// Back end: window slots, in-order delivery, flush counting and the result register.
// Depends on srw_pkg.
module srw_back
   import srw_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int IdxW  = $clog2(WINDOW_MAX);
   localparam int SizeW = $clog2(WINDOW_MAX + 1);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_HEAD      = 6'b000010,
      ST_DELIV     = 6'b000100,
      ST_FLUSH     = 6'b001000,
      ST_END_FLUSH = 6'b010000,
      ST_END_MARK  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cur_ff, cur_in;
   logic [SEQ_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              filled_ff [WINDOW_MAX];
   logic              filled_in [WINDOW_MAX];
   logic [LEN_W-1:0]  len_ff    [WINDOW_MAX];
   logic [LEN_W-1:0]  len_in    [WINDOW_MAX];
   logic [REF_W-1:0]  handle_ff [WINDOW_MAX];
   logic [REF_W-1:0]  handle_in [WINDOW_MAX];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [SizeW-1:0]  live_size;
   logic [CNT_W-1:0]  live_limit;
   logic [SEQ_W:0]    win_end;
   logic              in_win;
   logic              at_or_above;
   logic [SEQ_W-1:0]  offset;
   logic [IdxW-1:0]   idx;
   logic              flush_due;
   logic              deliver_go;
   logic [CNT_W:0]    count_inc;
   logic              more;
   logic              flush_after;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (cfg.window_size == '0) begin
         live_size = SizeW'(1);
      end else if (32'(cfg.window_size) > WINDOW_MAX) begin
         live_size = SizeW'(WINDOW_MAX);
      end else begin
         live_size = SizeW'(cfg.window_size);
      end
   end

   assign live_limit  = (cfg.buffer_limit == '0) ? CNT_W'(1) : cfg.buffer_limit;
   assign win_end     = {1'b0, start_ff} + (SEQ_W + 1)'(live_size);
   assign in_win      = {1'b0, cur_ff.seq} < win_end;
   assign at_or_above = cur_ff.seq >= start_ff;
   assign offset      = cur_ff.seq - start_ff;
   assign idx         = offset[IdxW-1:0];
   assign flush_due   = count_ff >= live_limit;
   // slot 0 counts as filled when this packet lands in it
   assign deliver_go  = at_or_above && (filled_ff[0] || idx == '0) && !flush_due;
   assign count_inc   = {1'b0, count_ff} + 1'b1;
   assign more        = filled_ff[1] && (count_inc < {1'b0, live_limit});
   assign flush_after = count_inc >= {1'b0, live_limit};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      filled_in    = filled_ff;
      len_in       = len_ff;
      handle_in    = handle_ff;
      cmd_pop      = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            unique case (cur_ff.op)
               OP_NACK: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_NACK, cur_ff.seq, '0, '0, !flush_due};
                     state_in     = flush_due ? ST_FLUSH : ST_IDLE;
                  end
               end
               OP_END: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_ACK, '0, '0, '0, 1'b0};
                     state_in     = ST_END_FLUSH;
                  end
               end
               OP_DATA: begin
                  if (!in_win) begin
                     // beyond the window: silent unless a flush is owed
                     state_in = flush_due ? ST_FLUSH : ST_IDLE;
                  end else if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{KIND_ACK, cur_ff.seq, '0, '0,
                                      !deliver_go && !flush_due};
                     if (at_or_above) begin
                        filled_in[idx] = 1'b1;
                        len_in[idx]    = cur_ff.len;
                        handle_in[idx] = cur_ff.handle;
                     end
                     if (deliver_go) begin
                        state_in = ST_DELIV;
                     end else begin
                        state_in = flush_due ? ST_FLUSH : ST_IDLE;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DELIV: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_DELIVER, start_ff, len_ff[0], handle_ff[0],
                                !more && !flush_after};
               count_in     = CNT_W'(count_inc);
               start_in     = start_ff + 1'b1;
               // slide every slot down by one
               for (int i = 0; i < WINDOW_MAX - 1; i++) begin
                  filled_in[i] = filled_ff[i + 1];
                  len_in[i]    = len_ff[i + 1];
                  handle_in[i] = handle_ff[i + 1];
               end
               filled_in[WINDOW_MAX - 1] = 1'b0;
               if (more) begin
                  state_in = ST_DELIV;
               end else begin
                  state_in = flush_after ? ST_FLUSH : ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_FLUSH, '0, '0, '0, 1'b1};
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_END_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_FLUSH, '0, '0, '0, 1'b0};
               count_in     = '0;
               state_in     = ST_END_MARK;
            end
         end
         ST_END_MARK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_END, '0, '0, '0, 1'b1};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= WINDOW_START_RST;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_MAX; i++) begin
            filled_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         filled_ff    <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      rsp_ff    <= rsp_in;
      len_ff    <= len_in;
      handle_ff <= handle_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/core/selective_repeat_receive_window.sv =====
// Top level of the selective-repeat receive window: register port, front end, queue, back end.
// Depends on srw_pkg, srw_front, srw_cmd_queue and srw_back.
//
//   Channel  Direction  Beat carries
//   req_*    in         tuser: checksum_ok; tdata: seq_num, payload_len, payload_ref
//   rsp_*    out        tuser: kind; tdata: seq_out, len_out, ref_out; tlast: last
//   csr_*    in/out     window_size at 0x0, buffer_limit at 0x4
//
// A packet is picked up from the queue and then handled in the head step, where it is
// acknowledged, NACKed or stored; any deliveries follow, then a flush marker if one is owed,
// and an end packet gives three results. The back end emits one result per cycle into the
// output register while rsp_tready does not stall it.
// Reset is synchronous: window start 1, all slots empty, count zero, window_size 8,
// buffer_limit 256. The two-entry queue lets the front keep taking beats while the back
// waits on rsp_tready; a stalled result holds in the output register.
module selective_repeat_receive_window
   import srw_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TDATA_W-1:0]    req_tdata,   // seq_num, payload_len, payload_ref, zero pad
   input  logic                  req_tuser,   // checksum_ok

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [TDATA_W-1:0]    rsp_tdata,   // seq_out, len_out, ref_out, zero pad
   output logic [KIND_W-1:0]     rsp_tuser,   // kind
   output logic                  rsp_tlast,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [WSIZE_W-1:0] window_size_ff;
   logic [CNT_W-1:0]   buffer_limit_ff;
   logic               csr_write;
   csr_reg_type        csr_reg;

   logic               push;
   cmd_type            push_cmd;
   logic               queue_full;
   logic               queue_not_empty;
   cmd_type            queue_head;
   logic               cmd_pop;
   cfg_type            cfg;
   rsp_type            rsp;

   // ---- register port: always ready, write on the access cycle
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff  <= WINDOW_SIZE_RST;
         buffer_limit_ff <= BUFFER_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_reg)
            CSR_WINDOW_SIZE:  window_size_ff  <= csr_pwdata[WSIZE_W-1:0];
            CSR_BUFFER_LIMIT: buffer_limit_ff <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         CSR_WINDOW_SIZE:  csr_prdata = CSR_DATA_W'(window_size_ff);
         CSR_BUFFER_LIMIT: csr_prdata = CSR_DATA_W'(buffer_limit_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = '{window_size: window_size_ff, buffer_limit: buffer_limit_ff};

   // ---- front end: classify beats, drop everything after the end packet
   srw_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_ok     (req_tuser),
      .req_seq    (req_tdata[SEQ_LO +: SEQ_W]),
      .req_len    (req_tdata[LEN_LO +: LEN_W]),
      .req_handle (req_tdata[REF_LO +: REF_W]),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // ---- decoupling queue
   srw_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (cmd_pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // ---- back end: window, delivery and result register
   srw_back #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (queue_not_empty),
      .cmd       (queue_head),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // ---- pack the result beat
   always_comb begin
      rsp_tdata                    = '0;
      rsp_tdata[SEQ_LO +: SEQ_W]   = rsp.seq;
      rsp_tdata[LEN_LO +: LEN_W]   = rsp.len;
      rsp_tdata[REF_LO +: REF_W]   = rsp.handle;
   end

   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule
